// ----- hdl/ssb_pkg.sv -----
package ssb_pkg;

  localparam int SSB_MAX_DIM = 4096;
  localparam int MAX_SCALE   = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OFFSET_W   = 25;
  localparam int FB_DIM_W   = 13;
  localparam int PITCH_W    = 14;
  localparam int SCALE_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FB_PITCH  = 3'd7;

  typedef struct packed {
    logic [31:0] pixel_in;
    logic        last_in;
  } in_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] pixel_offset;
    logic [31:0]         pixel_value;
    logic                last_of_run;
  } out_t;

  typedef struct packed {
    logic signed [15:0]  origin_x;
    logic signed [15:0]  origin_y;
    logic [SCALE_W-1:0]  scale_x;
    logic [SCALE_W-1:0]  scale_y;
    logic [FB_DIM_W-1:0] src_width;
    logic [FB_DIM_W-1:0] fb_width;
    logic [FB_DIM_W-1:0] fb_height;
    logic [PITCH_W-1:0]  fb_pitch;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic clip;
    logic base;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic transparent;
    logic empty;
    logic run_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] s);
    logic [SCALE_W-1:0] r;
    r = s;
    if (s == '0) begin
      r = SCALE_W'(1);
    end else if (s > SCALE_W'(MAX_SCALE)) begin
      r = SCALE_W'(MAX_SCALE);
    end
    return r;
  endfunction

endpackage

// ----- hdl/ssb_cfg.sv -----
module ssb_cfg
  import ssb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x  <= '0;
      cfg_q.origin_y  <= '0;
      cfg_q.scale_x   <= SCALE_W'(1);
      cfg_q.scale_y   <= SCALE_W'(1);
      cfg_q.src_width <= FB_DIM_W'(1);
      cfg_q.fb_width  <= FB_DIM_W'(1024);
      cfg_q.fb_height <= FB_DIM_W'(768);
      cfg_q.fb_pitch  <= PITCH_W'(1024);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ORIGIN_X:  cfg_q.origin_x  <= $signed(cfg_data_i);
        REG_ORIGIN_Y:  cfg_q.origin_y  <= $signed(cfg_data_i);
        REG_SCALE_X:   cfg_q.scale_x   <= cfg_data_i[SCALE_W-1:0];
        REG_SCALE_Y:   cfg_q.scale_y   <= cfg_data_i[SCALE_W-1:0];
        REG_SRC_WIDTH: cfg_q.src_width <= cfg_data_i[FB_DIM_W-1:0];
        REG_FB_WIDTH:  cfg_q.fb_width  <= cfg_data_i[FB_DIM_W-1:0];
        REG_FB_HEIGHT: cfg_q.fb_height <= cfg_data_i[FB_DIM_W-1:0];
        REG_FB_PITCH:  cfg_q.fb_pitch  <= cfg_data_i[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/ssb_ctrl.sv -----
module ssb_ctrl
  import ssb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CLIP = 2'd1;
  localparam logic [1:0] ST_BASE = 2'd2;
  localparam logic [1:0] ST_RUN  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    state_d    = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!status_i.transparent) begin
            state_d = ST_CLIP;
          end
        end
      end
      ST_CLIP: begin
        cmd_o.clip = 1'b1;
        state_d    = status_i.empty ? ST_IDLE : ST_BASE;
      end
      ST_BASE: begin
        cmd_o.base = 1'b1;
        state_d    = ST_RUN;
      end
      ST_RUN: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.run_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/ssb_dp.sv -----
module ssb_dp
  import ssb_pkg::*;
#(
  parameter int MAX_DIM = SSB_MAX_DIM
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  in_t        in_data_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o
);

  localparam int CW   = $clog2(MAX_DIM);
  localparam int PW   = CW + SCALE_W;
  localparam int CrdW = ((PW > 16) ? PW : 16) + 2;

  logic [CW-1:0] col_q, row_q;
  logic [CW:0]   col_inc, row_inc;
  logic [PITCH_W-1:0] w_eff;

  logic [SCALE_W-1:0] sx, sy;
  logic [PW-1:0]      prod_x, prod_y;
  logic signed [CrdW-1:0] bx_q, by_q, bx_d, by_d;
  logic [31:0] pix_q;

  logic signed [CrdW-1:0] x0, x1, y0, y1, xe, ye, fbw_m1, fbh_m1;
  logic [FB_DIM_W-1:0] x_q, x0_q, x1_q, y_q, y1_q;
  logic [OFFSET_W-1:0] off_q, rowoff_q, pitch_ext;
  logic [PITCH_W+FB_DIM_W-1:0] base_prod;
  logic run_last;

  out_t out_q;
  logic out_valid_q;

  assign sx = clamp_scale(cfg_i.scale_x);
  assign sy = clamp_scale(cfg_i.scale_y);

  always_comb begin
    w_eff = {1'b0, cfg_i.src_width};
    if (cfg_i.src_width == '0) begin
      w_eff = PITCH_W'(1);
    end else if (w_eff > PITCH_W'(MAX_DIM)) begin
      w_eff = PITCH_W'(MAX_DIM);
    end
  end

  assign col_inc = {1'b0, col_q} + (CW+1)'(1);
  assign row_inc = {1'b0, row_q} + (CW+1)'(1);

  assign prod_x = PW'(col_q) * PW'(sx);
  assign prod_y = PW'(row_q) * PW'(sy);
  assign bx_d = CrdW'(cfg_i.origin_x) + CrdW'($signed({1'b0, prod_x}));
  assign by_d = CrdW'(cfg_i.origin_y) + CrdW'($signed({1'b0, prod_y}));

  assign fbw_m1 = CrdW'($signed({1'b0, cfg_i.fb_width})) - CrdW'(1);
  assign fbh_m1 = CrdW'($signed({1'b0, cfg_i.fb_height})) - CrdW'(1);
  assign xe = bx_q + CrdW'($signed({1'b0, sx})) - CrdW'(1);
  assign ye = by_q + CrdW'($signed({1'b0, sy})) - CrdW'(1);
  assign x0 = (bx_q < 0) ? '0 : bx_q;
  assign y0 = (by_q < 0) ? '0 : by_q;
  assign x1 = (xe < fbw_m1) ? xe : fbw_m1;
  assign y1 = (ye < fbh_m1) ? ye : fbh_m1;

  assign pitch_ext = OFFSET_W'(cfg_i.fb_pitch);
  assign base_prod = (PITCH_W+FB_DIM_W)'(cfg_i.fb_pitch) * (PITCH_W+FB_DIM_W)'(y_q);
  assign run_last  = (x_q == x1_q) && (y_q == y1_q);

  assign status_o.transparent = (in_data_i.pixel_in == '0);
  assign status_o.empty       = (x0 > x1) || (y0 > y1);
  assign status_o.run_last    = run_last;
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (in_data_i.last_in) begin
          col_q <= '0;
          row_q <= '0;
        end else if (PITCH_W'(col_inc) >= w_eff) begin
          col_q <= '0;
          row_q <= (row_inc >= (CW+1)'(MAX_DIM)) ? '0 : row_inc[CW-1:0];
        end else begin
          col_q <= col_inc[CW-1:0];
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_q <= in_data_i.pixel_in;
      bx_q  <= bx_d;
      by_q  <= by_d;
    end
    if (cmd_i.clip) begin
      x_q  <= x0[FB_DIM_W-1:0];
      x0_q <= x0[FB_DIM_W-1:0];
      x1_q <= x1[FB_DIM_W-1:0];
      y_q  <= y0[FB_DIM_W-1:0];
      y1_q <= y1[FB_DIM_W-1:0];
    end
    if (cmd_i.base) begin
      off_q    <= base_prod[OFFSET_W-1:0] + OFFSET_W'(x0_q);
      rowoff_q <= base_prod[OFFSET_W-1:0] + OFFSET_W'(x0_q);
    end
    if (cmd_i.emit) begin
      out_q.pixel_offset <= off_q;
      out_q.pixel_value  <= pix_q;
      out_q.last_of_run  <= run_last;
      if (x_q == x1_q) begin
        x_q      <= x0_q;
        y_q      <= y_q + FB_DIM_W'(1);
        rowoff_q <= rowoff_q + pitch_ext;
        off_q    <= rowoff_q + pitch_ext;
      end else begin
        x_q   <= x_q + FB_DIM_W'(1);
        off_q <= off_q + OFFSET_W'(1);
      end
    end
  end

endmodule

// ----- hdl/scaled_sprite_blit_clipped_unit.sv -----
// Nearest-neighbor upscaling sprite blitter with frame clipping.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes source pixels in
// raster order; a zero pixel is transparent. Each opaque pixel is replicated
// into a scale_x by scale_y block at the configured origin, and every target
// inside the frame leaves on the output channel (out_valid_o / out_stall_i /
// out_data_o) as one write request of offset (x + pitch*y) and value, rows in
// order, left to right. last_of_run flags the final request of a pixel.
// Configuration: cfg_valid_i / cfg_ready_o with a 3-bit register index and
// 16-bit data; ready is always high. Write registers only while idle.
// Steps: a transparent pixel is only accepted; a fully clipped pixel is
// accepted and clipped. A visible pixel is accepted, clipped and given its
// row-base multiply, then issues one write request per cycle while the
// output is not stalled. The output register lets the next pixel be accepted
// while the last request waits. When out_stall_i is high and the output
// register is full, the request loop holds and the output holds its payload.
// Reset clears the source column and row, empties the output register and
// loads the register defaults.
module scaled_sprite_blit_clipped_unit
  import ssb_pkg::*;
#(
  parameter int MAX_DIM = SSB_MAX_DIM
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  ssb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ssb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ssb_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- dv/blit_monitor.sv -----
module blit_monitor
  import ssb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_t                   in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_t                  out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    errors_o,
  output int                    pending_o
);

  cfg_t regs;
  int   column;
  int   row;
  out_t due_writes[$];
  out_t want;

  task automatic flag_mismatch(input string what);
    if (errors_o < 200) begin
      $display("blit_monitor: %s", what);
    end
    errors_o++;
  endtask

  task automatic replicate_pixel(input in_t px);
    int     sx, sy, w, bx, by, xp, yp, ix, iy;
    longint off;
    out_t   wr;
    bit     held;
    sx = (regs.scale_x == '0) ? 1 :
         ((int'(regs.scale_x) > MAX_SCALE) ? MAX_SCALE : int'(regs.scale_x));
    sy = (regs.scale_y == '0) ? 1 :
         ((int'(regs.scale_y) > MAX_SCALE) ? MAX_SCALE : int'(regs.scale_y));
    w  = (regs.src_width == '0) ? 1 :
         ((int'(regs.src_width) > SSB_MAX_DIM) ? SSB_MAX_DIM : int'(regs.src_width));
    held = 1'b0;
    wr = '0;
    if (px.pixel_in != '0) begin
      bx = int'($signed(regs.origin_x)) + column * sx;
      by = int'($signed(regs.origin_y)) + row * sy;
      for (iy = 0; iy < sy; iy++) begin
        yp = by + iy;
        if (yp >= 0 && yp < int'(regs.fb_height)) begin
          for (ix = 0; ix < sx; ix++) begin
            xp = bx + ix;
            if (xp >= 0 && xp < int'(regs.fb_width)) begin
              if (held) begin
                due_writes.push_back(wr);
              end
              off = longint'(xp) + longint'(regs.fb_pitch) * longint'(yp);
              wr.pixel_offset = off[OFFSET_W-1:0];
              wr.pixel_value  = px.pixel_in;
              wr.last_of_run  = 1'b0;
              held = 1'b1;
            end
          end
        end
      end
      if (held) begin
        wr.last_of_run = 1'b1;
        due_writes.push_back(wr);
      end
    end
    if (px.last_in) begin
      column = 0;
      row    = 0;
    end else if (column + 1 >= w) begin
      column = 0;
      row    = (row + 1 >= SSB_MAX_DIM) ? 0 : row + 1;
    end else begin
      column++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = '{origin_x: 16'sd0, origin_y: 16'sd0, scale_x: 4'd1, scale_y: 4'd1,
               src_width: 13'd1, fb_width: 13'd1024, fb_height: 13'd768,
               fb_pitch: 14'd1024};
      column = 0;
      row    = 0;
      due_writes.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_writes.size() == 0) begin
          flag_mismatch($sformatf("unexpected request offset %0h value %0h last %0b",
                                  out_data_i.pixel_offset, out_data_i.pixel_value,
                                  out_data_i.last_of_run));
        end else begin
          want = due_writes.pop_front();
          if (out_data_i.pixel_offset !== want.pixel_offset) begin
            flag_mismatch($sformatf("offset %0h, want %0h",
                                    out_data_i.pixel_offset, want.pixel_offset));
          end
          if (out_data_i.pixel_value !== want.pixel_value) begin
            flag_mismatch($sformatf("value %0h, want %0h at offset %0h",
                                    out_data_i.pixel_value, want.pixel_value,
                                    want.pixel_offset));
          end
          if (out_data_i.last_of_run !== want.last_of_run) begin
            flag_mismatch($sformatf("last_of_run %0b, want %0b at offset %0h",
                                    out_data_i.last_of_run, want.last_of_run,
                                    want.pixel_offset));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        replicate_pixel(in_data_i);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ORIGIN_X:  regs.origin_x  = cfg_data_i;
          REG_ORIGIN_Y:  regs.origin_y  = cfg_data_i;
          REG_SCALE_X:   regs.scale_x   = cfg_data_i[SCALE_W-1:0];
          REG_SCALE_Y:   regs.scale_y   = cfg_data_i[SCALE_W-1:0];
          REG_SRC_WIDTH: regs.src_width = cfg_data_i[FB_DIM_W-1:0];
          REG_FB_WIDTH:  regs.fb_width  = cfg_data_i[FB_DIM_W-1:0];
          REG_FB_HEIGHT: regs.fb_height = cfg_data_i[FB_DIM_W-1:0];
          REG_FB_PITCH:  regs.fb_pitch  = cfg_data_i[PITCH_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = due_writes.size();
  end

endmodule

// ----- dv/tb.sv -----
module tb;
  import ssb_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int errors;
  int pending;
  int cycle_count = 0;
  int image_w = 1;
  bit steady = 1'b0;
  int stall_left = 0;
  bit stall_hold = 1'b0;
  int stall_pick;

  scaled_sprite_blit_clipped_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  blit_monitor watch (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_pick = $urandom_range(99);
      if (stall_pick < 15) begin
        stall_hold = 1'b0;
        stall_left = $urandom_range(200, 50);
      end else if (stall_pick < 55) begin
        stall_hold = 1'b0;
        stall_left = $urandom_range(4, 1);
      end else if (stall_pick < 92) begin
        stall_hold = 1'b1;
        stall_left = $urandom_range(3, 1);
      end else begin
        stall_hold = 1'b1;
        stall_left = $urandom_range(40, 10);
      end
    end else begin
      stall_left--;
    end
    out_stall <= stall_hold;
  end

  function automatic logic [31:0] opaque();
    logic [31:0] v;
    v = $urandom;
    return (v == '0) ? 32'd1 : v;
  endfunction

  function automatic int pick_scale();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(4, 1);
    if (r < 93) return $urandom_range(MAX_SCALE, 5);
    return (r < 96) ? 0 : $urandom_range(15, 9);
  endfunction

  function automatic int pick_extent();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(64, 4);
    if (r < 93) return $urandom_range(SSB_MAX_DIM, 65);
    return $urandom_range(8191);
  endfunction

  function automatic int pick_origin();
    return ($urandom_range(99) < 80) ? $urandom_range(64) - 24 : $urandom_range(65535) - 32768;
  endfunction

  task automatic send(input logic [31:0] pix, input logic last);
    int gap;
    int r;
    r = $urandom_range(99);
    if (steady || r < 55) gap = 0;
    else if (r < 85) gap = $urandom_range(3, 1);
    else if (r < 95) gap = $urandom_range(8, 4);
    else gap = $urandom_range(40, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{pixel_in: pix, last_in: last};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int field, input int bits);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(($urandom << bits) | (field & ((1 << bits) - 1)));
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(input int ox, input int oy, input int sx, input int sy,
                           input int sw, input int fw, input int fh, input int fp);
    settle();
    write_reg(REG_ORIGIN_X, ox, 16);
    write_reg(REG_ORIGIN_Y, oy, 16);
    write_reg(REG_SCALE_X, sx, SCALE_W);
    write_reg(REG_SCALE_Y, sy, SCALE_W);
    write_reg(REG_SRC_WIDTH, sw, FB_DIM_W);
    write_reg(REG_FB_WIDTH, fw, FB_DIM_W);
    write_reg(REG_FB_HEIGHT, fh, FB_DIM_W);
    write_reg(REG_FB_PITCH, fp, PITCH_W);
    cfg_valid <= 1'b0;
    image_w = (sw == 0) ? 1 : ((sw > SSB_MAX_DIM) ? SSB_MAX_DIM : sw);
  endtask

  initial begin
    int sent, n, cut, r, fw;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(32'd0, 1'b0);
    send(32'hFFFF_FFFF, 1'b0);
    send(32'd1, 1'b0);
    send(32'h8000_0000, 1'b1);

    configure(-32768, 32767, 1, 1, 4, 1024, 768, 1024);
    send(opaque(), 1'b0);
    send(opaque(), 1'b0);
    configure(32767, -32768, 2, 2, 4, 1024, 768, 1024);
    send(opaque(), 1'b0);
    send(opaque(), 1'b1);

    configure(-3, -2, 15, 15, 0, 5, 6, 8192);
    send(opaque(), 1'b0);
    send(opaque(), 1'b1);
    send(opaque(), 1'b0);

    configure(2, 1, 0, 0, 8191, 0, 10, 100);
    send(opaque(), 1'b0);
    send(opaque(), 1'b0);
    configure(2, 1, 0, 0, 8191, 10, 0, 100);
    send(opaque(), 1'b0);
    send(opaque(), 1'b0);
    configure(1, 1, 0, 0, 8191, 10, 10, 100);
    send(opaque(), 1'b0);
    send(opaque(), 1'b1);

    configure(0, 8000, 8, 8, 2, 8191, 8191, 16383);
    send(opaque(), 1'b0);
    send(opaque(), 1'b0);
    send(opaque(), 1'b0);
    configure(8180, 8000, 8, 8, 2, 8191, 8191, 16383);
    send(opaque(), 1'b0);
    send(opaque(), 1'b1);

    for (int ph = 0; ph < 7; ph++) begin
      r  = $urandom_range(99);
      fw = pick_extent();
      configure(pick_origin(), pick_origin(), pick_scale(), pick_scale(),
                (r < 85) ? $urandom_range(12, 1) :
                ((r < 95) ? $urandom_range(300, 13) : $urandom_range(8191)),
                fw, pick_extent(),
                ($urandom_range(99) < 85) ? ((fw + $urandom_range(16)) & 16'h3FFF)
                                          : $urandom_range(16383));
      sent = 0;
      while (sent < 37) begin
        steady = ($urandom_range(3) == 0);
        n = image_w * $urandom_range(4, 1);
        if (n > 37 - sent) n = 37 - sent;
        r = $urandom_range(9);
        cut = (r == 0) ? $urandom_range(n - 1) : ((r == 1) ? n : n - 1);
        for (int k = 0; k < n; k++) begin
          send(($urandom_range(3) == 0) ? 32'd0 : opaque(), k == cut);
        end
        sent += n;
      end
    end

    settle();
    repeat (16) @(negedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ssb_pkg.sv
hdl/ssb_cfg.sv
hdl/ssb_ctrl.sv
hdl/ssb_dp.sv
hdl/scaled_sprite_blit_clipped_unit.sv
dv/blit_monitor.sv
dv/tb.sv
